FILE: hdl/assert_macros.svh
// Assertion macros shared by the command sentence checker modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checks a property on every rising edge of i_clk outside reset.
`define CCS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("command sentence checker: assertion failed");
// Checks that a condition never holds on a rising edge of i_clk outside reset.
`define CCS_NEVER(label, expr) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) \
        else $error("command sentence checker: forbidden condition seen");
`else
`define CCS_ASSERT(label, prop)
`define CCS_NEVER(label, expr)
`endif
`endif

FILE: hdl/ccs_pkg.sv
// Types, character constants and decode functions of the command sentence checker.
package ccs_pkg;

    // Framing characters and hex decode offsets.
    localparam logic [7:0] CHAR_DOLLAR = 8'h24;
    localparam logic [7:0] CHAR_STAR   = 8'h2A;
    localparam logic [7:0] DIGIT_BASE  = 8'h30;
    localparam logic [7:0] ALPHA_BASE  = 8'h37;

    // Command codes.
    localparam logic [3:0] CODE_NONE = 4'd0;
    localparam logic [3:0] CODE_CVW  = 4'd1;
    localparam logic [3:0] CODE_DPV  = 4'd2;
    localparam logic [3:0] CODE_SWV  = 4'd3;
    localparam logic [3:0] CODE_EIS  = 4'd4;
    localparam logic [3:0] CODE_RUN  = 4'd5;
    localparam logic [3:0] CODE_CHK  = 4'd6;
    localparam logic [3:0] CODE_DIE  = 4'd7;
    localparam logic [3:0] CODE_TIA  = 4'd8;
    localparam logic [3:0] CODE_CUR  = 4'd9;
    localparam logic [3:0] CODE_MAX  = CODE_CUR;

    // Three-letter names, first letter in the top byte.
    localparam logic [23:0] NAME_CVW = 24'h435657;
    localparam logic [23:0] NAME_DPV = 24'h445056;
    localparam logic [23:0] NAME_SWV = 24'h535756;
    localparam logic [23:0] NAME_EIS = 24'h454953;
    localparam logic [23:0] NAME_CMD = 24'h434D44;
    localparam logic [23:0] NAME_RUN = 24'h52554E;
    localparam logic [23:0] NAME_CHK = 24'h43484B;
    localparam logic [23:0] NAME_DIE = 24'h444945;
    localparam logic [23:0] NAME_TIA = 24'h544941;
    localparam logic [23:0] NAME_CUR = 24'h435552;

    // One finished sentence as the front hands it over.
    typedef struct packed {
        logic [5:0][7:0] code_chars;   // positions 1,2,3,5,6,7 at indexes 0..5
        logic [7:0]      computed_sum;
        logic [7:0]      received_sum;
        logic            digit_bad;
    } t_sentence;

    // One result as it stands on the output ports.
    typedef struct packed {
        logic       checksum_ok;
        logic       hex_error;
        logic [3:0] command_code;
        logic [7:0] computed_sum;
        logic [7:0] received_sum;
    } t_result;

    // Uppercase hex decode: bad flag in the top bit, nibble below it.
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [7:0] diff;
        logic [4:0] res;
        diff = 8'd0;
        res  = 5'b1_0000;
        case (c) inside
            [8'h30:8'h39]: begin
                diff = c - DIGIT_BASE;
                res  = {1'b0, diff[3:0]};
            end
            [8'h41:8'h46]: begin
                diff = c - ALPHA_BASE;
                res  = {1'b0, diff[3:0]};
            end
            default: begin
                res = 5'b1_0000;
            end
        endcase
        return res;
    endfunction

    // Command lookup over the kept characters.
    function automatic logic [3:0] find_code(input logic [5:0][7:0] chars);
        logic [23:0] first;
        logic [23:0] second;
        logic [3:0]  code;
        first  = {chars[0], chars[1], chars[2]};
        second = {chars[3], chars[4], chars[5]};
        code   = CODE_NONE;
        if (first == NAME_CVW) begin
            code = CODE_CVW;
        end else if (first == NAME_DPV) begin
            code = CODE_DPV;
        end else if (first == NAME_SWV) begin
            code = CODE_SWV;
        end else if (first == NAME_EIS) begin
            code = CODE_EIS;
        end else if (first == NAME_CMD) begin
            if (second == NAME_RUN) begin
                code = CODE_RUN;
            end else if (second == NAME_CHK) begin
                code = CODE_CHK;
            end else if (second == NAME_DIE) begin
                code = CODE_DIE;
            end else if (second == NAME_TIA) begin
                code = CODE_TIA;
            end else if (second == NAME_CUR) begin
                code = CODE_CUR;
            end
        end
        return code;
    endfunction

endpackage

FILE: hdl/command_sentence_checker.sv
// Top level of the command sentence checker.
// Checks "$...*HH" command sentences fed one byte per cycle: a byte is taken on every
// clock edge with push high and full low. When the second checksum digit is taken, the
// sentence is queued; its result (checksum match, hex error, command code, computed and
// received checksum) is registered onto the result ports when the output register is free,
// and stays until popped. Finished sentences wait in a QUEUE_DEPTH-entry queue
// behind a one-entry output register, so full rises only when that many results plus the
// one on the ports are all unclaimed; it depends on the queue fill alone, not on the byte.
module command_sentence_checker
    import ccs_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       push,
    output logic       full,
    input  logic [7:0] i_byte_in,
    output logic       empty,
    input  logic       pop,
    output logic       o_checksum_ok,
    output logic       o_hex_error,
    output logic [3:0] o_command_code,
    output logic [7:0] o_computed_sum,
    output logic [7:0] o_received_sum
);

    logic      w_accept;
    logic      w_wr_en;
    t_sentence w_wr_data;
    t_sentence w_rd_data;
    logic      w_q_rd;
    logic      w_q_full;
    logic      w_q_empty;
    logic      w_valid;
    t_result   w_result;

    assign full     = w_q_full;
    assign w_accept = push && !w_q_full;

    // Byte parser.
    ccs_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_byte_in  (i_byte_in),
        .o_wr_en    (w_wr_en),
        .o_sentence (w_wr_data)
    );

    // Sentence queue.
    ccs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_q_rd),
        .o_rd_data (w_rd_data),
        .o_full    (w_q_full),
        .o_empty   (w_q_empty)
    );

    // Result stage.
    ccs_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (w_q_empty),
        .i_sentence (w_rd_data),
        .o_q_rd     (w_q_rd),
        .i_pop      (pop),
        .o_valid    (w_valid),
        .o_result   (w_result)
    );

    assign empty          = !w_valid;
    assign o_checksum_ok  = w_result.checksum_ok;
    assign o_hex_error    = w_result.hex_error;
    assign o_command_code = w_result.command_code;
    assign o_computed_sum = w_result.computed_sum;
    assign o_received_sum = w_result.received_sum;

endmodule

FILE: hdl/ccs_front.sv
// Front end: framing, running XOR, character capture and checksum digit decode.
`include "assert_macros.svh"
module ccs_front
    import ccs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_accept,
    input  logic [7:0] i_byte_in,
    output logic      o_wr_en,
    output t_sentence o_sentence
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_HIGH = 2'd2;
    localparam logic [1:0] PH_LOW  = 2'd3;

    logic [1:0]      r_phase,  n_phase;
    logic [7:0]      r_xor,    n_xor;
    logic [3:0]      r_pos,    n_pos;
    logic [5:0][7:0] r_chars,  n_chars;
    logic [3:0]      r_high,   n_high;
    logic            r_bad,    n_bad;
    logic [4:0]      w_dec;

    assign w_dec = hex_decode(i_byte_in);

    // Sentence output toward the queue, built from the low digit.
    assign o_wr_en = i_accept && (r_phase == PH_LOW) && (i_byte_in != CHAR_DOLLAR);
    assign o_sentence.code_chars   = r_chars;
    assign o_sentence.computed_sum = r_xor;
    assign o_sentence.received_sum = {r_high, w_dec[3:0]};
    assign o_sentence.digit_bad    = r_bad | w_dec[4];

    // Parser next state.
    always_comb begin
        n_phase = r_phase;
        n_xor   = r_xor;
        n_pos   = r_pos;
        n_chars = r_chars;
        n_high  = r_high;
        n_bad   = r_bad;
        if (i_accept) begin
            if (i_byte_in == CHAR_DOLLAR) begin
                n_phase = PH_BODY;
                n_xor   = 8'd0;
                n_pos   = 4'd0;
                n_chars = '0;
                n_high  = 4'd0;
                n_bad   = 1'b0;
            end else begin
                case (r_phase)
                    PH_BODY: begin
                        if (i_byte_in == CHAR_STAR) begin
                            n_phase = PH_HIGH;
                        end else begin
                            n_xor = r_xor ^ i_byte_in;
                            if (r_pos != 4'hF) begin
                                n_pos = r_pos + 4'd1;
                            end
                            case (n_pos)
                                4'd1: n_chars[0] = i_byte_in;
                                4'd2: n_chars[1] = i_byte_in;
                                4'd3: n_chars[2] = i_byte_in;
                                4'd5: n_chars[3] = i_byte_in;
                                4'd6: n_chars[4] = i_byte_in;
                                4'd7: n_chars[5] = i_byte_in;
                                default: n_chars = r_chars;
                            endcase
                        end
                    end
                    PH_HIGH: begin
                        n_high  = w_dec[3:0];
                        n_bad   = w_dec[4];
                        n_phase = PH_LOW;
                    end
                    PH_LOW: begin
                        n_phase = PH_IDLE;
                        n_xor   = 8'd0;
                        n_pos   = 4'd0;
                        n_chars = '0;
                        n_high  = 4'd0;
                        n_bad   = 1'b0;
                    end
                    default: begin
                        n_phase = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Parser state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_xor   <= 8'd0;
            r_pos   <= 4'd0;
            r_chars <= '0;
            r_high  <= 4'd0;
            r_bad   <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_xor   <= n_xor;
            r_pos   <= n_pos;
            r_chars <= n_chars;
            r_high  <= n_high;
            r_bad   <= n_bad;
        end
    end

    // A sentence leaves the front only from the low digit phase, and the parser idles after it.
    `CCS_ASSERT(a_front_wr_then_idle, o_wr_en |=> (r_phase == PH_IDLE))
    // The body position holds through the high digit phase unless a dollar sign restarts the sentence.
    `CCS_ASSERT(a_front_pos_still, (r_phase == PH_HIGH) && !(i_accept && (i_byte_in == CHAR_DOLLAR)) |=> $stable(r_pos))

endmodule

FILE: hdl/ccs_queue.sv
// Short queue of finished sentences between the front and back ends.
`include "assert_macros.svh"
module ccs_queue
    import ccs_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_wr_en,
    input  t_sentence i_wr_data,
    input  logic      i_rd_en,
    output t_sentence o_rd_data,
    output logic      o_full,
    output logic      o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_sentence        r_slots [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             w_wr, w_rd;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign w_wr      = i_wr_en && !o_full;
    assign w_rd      = i_rd_en && !o_empty;
    assign o_rd_data = r_slots[r_rd_ptr];

    // Slot storage.
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_slots[r_wr_ptr] <= i_wr_data;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (w_wr && !w_rd) begin
                r_count <= r_count + CW'(1);
            end else if (w_rd && !w_wr) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // The front never offers a sentence that the queue cannot take.
    `CCS_NEVER(a_queue_no_overflow, i_wr_en && o_full)
    // The fill count never exceeds the depth.
    `CCS_ASSERT(a_queue_count_bound, r_count <= CW'(DEPTH))

endmodule

FILE: hdl/ccs_back.sv
// Back end: command lookup, checksum compare and the result output register.
`include "assert_macros.svh"
module ccs_back
    import ccs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_sentence i_sentence,
    output logic      o_q_rd,
    input  logic      i_pop,
    output logic      o_valid,
    output t_result   o_result
);

    logic    r_valid;
    t_result r_result;
    t_result w_result;

    // Work out one result from the sentence at the head of the queue.
    always_comb begin
        w_result.checksum_ok  = !i_sentence.digit_bad
                                && (i_sentence.received_sum == i_sentence.computed_sum);
        w_result.hex_error    = i_sentence.digit_bad;
        w_result.command_code = find_code(i_sentence.code_chars);
        w_result.computed_sum = i_sentence.computed_sum;
        w_result.received_sum = i_sentence.received_sum;
    end

    // Take the next sentence whenever the output register is free or being emptied.
    assign o_q_rd = !i_q_empty && (!r_valid || i_pop);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_q_rd) begin
            r_valid <= 1'b1;
        end else if (i_pop) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_result <= w_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

    // A waiting result is never overwritten before it is taken.
    `CCS_ASSERT(a_back_hold, r_valid && !i_pop |=> r_valid && $stable(r_result))
    // Only command codes up to CODE_MAX, CODE_NONE included, leave the block.
    `CCS_ASSERT(a_back_code_range, r_valid |-> (r_result.command_code <= CODE_MAX))

endmodule

FILE: tb/command_sentence_checker_tb.sv
// Self-checking testbench for the command sentence checker: directed and random sentences.
module command_sentence_checker_tb;
    import ccs_pkg::*;

    // Run limits.
    localparam int BYTE_TARGET   = 800;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 20;

    // Ways to close a sentence after the asterisk.
    localparam int SUM_GOOD  = 0;
    localparam int SUM_WRONG = 1;
    localparam int SUM_LOWER = 2;
    localparam int SUM_JUNK  = 3;

    // Sentence shapes: 0-8 name a command in code order, then the odd ones.
    localparam int KIND_LAST_NAMED = 8;
    localparam int KIND_RANDOM_LEAD = 9;
    localparam int KIND_CMD_RANDOM = 10;
    localparam int KIND_SHORT = 11;

    typedef enum logic [1:0] {WAIT_DOLLAR, IN_BODY, WAIT_HIGH, WAIT_LOW} t_parse_phase;

    logic       i_clk;
    logic       i_rst_n;
    logic       push;
    logic       full;
    logic [7:0] i_byte_in;
    logic       empty;
    logic       pop;
    logic       o_checksum_ok;
    logic       o_hex_error;
    logic [3:0] o_command_code;
    logic [7:0] o_computed_sum;
    logic [7:0] o_received_sum;

    command_sentence_checker dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_byte_in      (i_byte_in),
        .empty          (empty),
        .pop            (pop),
        .o_checksum_ok  (o_checksum_ok),
        .o_hex_error    (o_hex_error),
        .o_command_code (o_command_code),
        .o_computed_sum (o_computed_sum),
        .o_received_sum (o_received_sum)
    );

    // Parser state as the testbench tracks it.
    t_parse_phase parse_phase;
    logic [7:0]   run_xor;
    int           body_pos;
    logic [7:0]   kept_chars [0:5];
    logic [3:0]   high_nibble;
    logic         high_bad;

    t_result      sentence_results [$];
    logic [7:0]   line_buf [$];

    bit sender_idles;
    bit reader_stalls;
    int fail_count;
    int parsed_bytes;
    int results_checked;
    int quiet_cycles;
    bit codes_seen [0:9];

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // Prints one mismatch and counts it.
    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        fail_count++;
    endtask

    // Uppercase hex digit test and value; anything else reads as nibble 0.
    function automatic bit is_upper_hex(input logic [7:0] c);
        return (c >= DIGIT_BASE && c <= DIGIT_BASE + 8'd9) ||
               (c >= ALPHA_BASE + 8'd10 && c <= ALPHA_BASE + 8'd15);
    endfunction

    function automatic logic [3:0] nibble_of(input logic [7:0] c);
        logic [7:0] d;
        d = 8'd0;
        if (c >= DIGIT_BASE && c <= DIGIT_BASE + 8'd9) begin
            d = c - DIGIT_BASE;
        end else if (c >= ALPHA_BASE + 8'd10 && c <= ALPHA_BASE + 8'd15) begin
            d = c - ALPHA_BASE;
        end
        return d[3:0];
    endfunction

    function automatic logic [7:0] hex_char(input logic [3:0] n);
        return (n < 4'd10) ? DIGIT_BASE + 8'(n) : ALPHA_BASE + 8'(n);
    endfunction

    // Command code from the characters at positions 1-3 and 5-7.
    function automatic logic [3:0] lookup_command(input logic [23:0] lead,
                                                  input logic [23:0] tail);
        case (lead)
            NAME_CVW: return CODE_CVW;
            NAME_DPV: return CODE_DPV;
            NAME_SWV: return CODE_SWV;
            NAME_EIS: return CODE_EIS;
            NAME_CMD: begin
                case (tail)
                    NAME_RUN: return CODE_RUN;
                    NAME_CHK: return CODE_CHK;
                    NAME_DIE: return CODE_DIE;
                    NAME_TIA: return CODE_TIA;
                    NAME_CUR: return CODE_CUR;
                    default:  return CODE_NONE;
                endcase
            end
            default: return CODE_NONE;
        endcase
    endfunction

    task automatic clear_parser();
        parse_phase = WAIT_DOLLAR;
        run_xor     = 8'd0;
        body_pos    = 0;
        high_nibble = 4'd0;
        high_bad    = 1'b0;
        foreach (kept_chars[i]) kept_chars[i] = 8'd0;
    endtask

    // Advances the tracked parser by one accepted byte and queues any result it gives.
    task automatic predict_byte(input logic [7:0] c);
        t_result    r;
        logic       bad;
        logic [7:0] recv;
        if (c == CHAR_DOLLAR || parse_phase != WAIT_DOLLAR) begin
            parsed_bytes++;
        end
        if (c == CHAR_DOLLAR) begin
            clear_parser();
            parse_phase = IN_BODY;
        end else begin
            case (parse_phase)
                IN_BODY: begin
                    if (c == CHAR_STAR) begin
                        parse_phase = WAIT_HIGH;
                    end else begin
                        run_xor = run_xor ^ c;
                        if (body_pos < 15) body_pos++;
                        if (body_pos >= 1 && body_pos <= 3) begin
                            kept_chars[body_pos - 1] = c;
                        end else if (body_pos >= 5 && body_pos <= 7) begin
                            kept_chars[body_pos - 2] = c;
                        end
                    end
                end
                WAIT_HIGH: begin
                    high_bad    = !is_upper_hex(c);
                    high_nibble = nibble_of(c);
                    parse_phase = WAIT_LOW;
                end
                WAIT_LOW: begin
                    bad            = high_bad || !is_upper_hex(c);
                    recv           = {high_nibble, nibble_of(c)};
                    r.checksum_ok  = !bad && (recv == run_xor);
                    r.hex_error    = bad;
                    r.command_code = lookup_command({kept_chars[0], kept_chars[1], kept_chars[2]},
                                                    {kept_chars[3], kept_chars[4], kept_chars[5]});
                    r.computed_sum = run_xor;
                    r.received_sum = recv;
                    sentence_results.push_back(r);
                    clear_parser();
                end
                default: begin
                end
            endcase
        end
    endtask

    // Offers one byte, after a random gap when sender_idles is set, and waits for its transfer.
    task automatic send_byte(input logic [7:0] c);
        int gap;
        gap = sender_idles ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push      <= 1'b1;
        i_byte_in <= c;
        do @(posedge i_clk); while (full !== 1'b0);
        predict_byte(c);
    endtask

    task automatic send_line();
        foreach (line_buf[i]) send_byte(line_buf[i]);
        line_buf.delete();
    endtask

    // Holds the input side until every queued result has been read.
    task automatic pause_until_drained();
        push <= 1'b0;
        do @(posedge i_clk); while (sentence_results.size() != 0);
    endtask

    task automatic add_text(input string s);
        for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    endtask

    task automatic add_name(input logic [23:0] n);
        line_buf.push_back(n[23:16]);
        line_buf.push_back(n[15:8]);
        line_buf.push_back(n[7:0]);
    endtask

    // A body character: printable or any byte, never a framing character.
    function automatic logic [7:0] body_char(input bit wide);
        logic [7:0] c;
        do begin
            c = wide ? 8'($urandom_range(0, 255)) : 8'($urandom_range(8'h20, 8'h7E));
        end while (c == CHAR_DOLLAR || c == CHAR_STAR);
        return c;
    endfunction

    function automatic logic [7:0] random_letter();
        return 8'($urandom_range(8'h41, 8'h5A));
    endfunction

    function automatic logic [23:0] command_name(input int k);
        case (k)
            0:       return NAME_CVW;
            1:       return NAME_DPV;
            2:       return NAME_SWV;
            3:       return NAME_EIS;
            4:       return NAME_RUN;
            5:       return NAME_CHK;
            6:       return NAME_DIE;
            7:       return NAME_TIA;
            8:       return NAME_CUR;
            default: return NAME_CMD;
        endcase
    endfunction

    // Starts a new line with a dollar sign and a body of the given shape.
    task automatic build_sentence(input int kind, input bit with_params);
        bit wide;
        line_buf.delete();
        line_buf.push_back(CHAR_DOLLAR);
        if (kind <= 3) begin
            add_name(command_name(kind));
        end else if (kind <= KIND_LAST_NAMED) begin
            add_name(NAME_CMD);
            line_buf.push_back(body_char(1'b0));
            add_name(command_name(kind));
        end else if (kind == KIND_RANDOM_LEAD) begin
            repeat (3) line_buf.push_back(random_letter());
        end else if (kind == KIND_CMD_RANDOM) begin
            add_name(NAME_CMD);
            line_buf.push_back(body_char(1'b0));
            repeat (3) line_buf.push_back(random_letter());
        end else begin
            repeat ($urandom_range(0, 2)) line_buf.push_back(body_char(1'b1));
        end
        if (with_params) begin
            wide = ($urandom_range(0, 3) == 0);
            repeat ($urandom_range(0, 12)) line_buf.push_back(body_char(wide));
        end
    endtask

    // Appends the asterisk and two checksum characters over the body in the line.
    task automatic add_checksum(input int mode);
        logic [7:0] sum;
        logic [7:0] hi;
        logic [7:0] lo;
        sum = 8'd0;
        for (int i = 1; i < line_buf.size(); i++) sum = sum ^ line_buf[i];
        line_buf.push_back(CHAR_STAR);
        if (mode == SUM_WRONG) begin
            sum = sum ^ 8'($urandom_range(1, 255));
        end
        hi = hex_char(sum[7:4]);
        lo = hex_char(sum[3:0]);
        if (mode == SUM_LOWER) begin
            if (hi >= "A") hi = hi | 8'h20;
            if (lo >= "A") lo = lo | 8'h20;
            if (hi < "A" && lo < "A") lo = 8'($urandom_range("a", "f"));
        end else if (mode == SUM_JUNK) begin
            do hi = 8'($urandom_range(0, 255)); while (hi == CHAR_DOLLAR);
            do lo = 8'($urandom_range(0, 255)); while (lo == CHAR_DOLLAR);
        end
        line_buf.push_back(hi);
        line_buf.push_back(lo);
    endtask

    // Result side: random stalls, and a field by field check of each transfer.
    task automatic check_result();
        t_result want;
        if (sentence_results.size() == 0) begin
            report_mismatch($sformatf("result with none pending, code %0d", o_command_code));
            return;
        end
        want = sentence_results.pop_front();
        results_checked++;
        codes_seen[want.command_code] = 1'b1;
        if (o_checksum_ok !== want.checksum_ok)
            report_mismatch($sformatf("checksum_ok %b, expected %b",
                                      o_checksum_ok, want.checksum_ok));
        if (o_hex_error !== want.hex_error)
            report_mismatch($sformatf("hex_error %b, expected %b", o_hex_error, want.hex_error));
        if (o_command_code !== want.command_code)
            report_mismatch($sformatf("command_code %0d, expected %0d",
                                      o_command_code, want.command_code));
        if (o_computed_sum !== want.computed_sum)
            report_mismatch($sformatf("computed_sum %h, expected %h",
                                      o_computed_sum, want.computed_sum));
        if (o_received_sum !== want.received_sum)
            report_mismatch($sformatf("received_sum %h, expected %h",
                                      o_received_sum, want.received_sum));
    endtask

    initial begin
        int stall;
        pop <= 1'b0;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            stall = reader_stalls ? $urandom_range(0, 10) : 0;
            if (stall > 0) begin
                pop <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty !== 1'b0);
            check_result();
        end
    end

    // Watchdog: ends the run when no transfer happens for too long.
    always @(posedge i_clk) begin
        if ((push === 1'b1 && full === 1'b0) || (pop === 1'b1 && empty === 1'b0)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("command_sentence_checker_tb failed");
            $finish;
        end
    end

    // Every command name with a correct checksum, one sentence each.
    task automatic test_commands();
        sender_idles  = 1'b1;
        reader_stalls = 1'b1;
        for (int k = 0; k <= KIND_LAST_NAMED; k++) begin
            build_sentence(k, 1'b0);
            add_checksum(SUM_GOOD);
            send_line();
        end
    endtask

    // Lowercase digits, an asterisk as a digit, a wrong sum and the sum extremes.
    task automatic test_checksum_faults();
        build_sentence(3, 1'b0);
        add_checksum(SUM_LOWER);
        add_text("$DPV**A");
        send_line();
        add_text("$CMDXRUN");
        add_checksum(SUM_WRONG);
        send_line();
        line_buf.push_back(CHAR_DOLLAR);
        line_buf.push_back(8'h00);
        line_buf.push_back(8'hFF);
        add_checksum(SUM_GOOD);
        add_text("$*00");
        send_line();
    endtask

    // Stray bytes while idle, restarts in the body and the digits, and a long body.
    task automatic test_restart_and_noise();
        add_text("xyz*9");
        add_text("$SWV*4");
        send_line();
        build_sentence(4, 1'b0);
        add_checksum(SUM_GOOD);
        send_line();
        add_text("$SWV");
        send_line();
        build_sentence(0, 1'b0);
        add_checksum(SUM_GOOD);
        send_line();
        add_text("$CMD,DIE,0123456789ABCDEF");
        add_checksum(SUM_GOOD);
        send_line();
    endtask

    // Short sentences back to back against a slow reader, then a full drain.
    task automatic test_backpressure();
        sender_idles  = 1'b0;
        reader_stalls = 1'b1;
        repeat (12) begin
            build_sentence(KIND_SHORT, 1'b0);
            add_checksum(SUM_GOOD);
            send_line();
        end
        pause_until_drained();
    endtask

    // Mostly well-formed sentences with random content, some noise and cut lines.
    task automatic test_random_traffic();
        int pick;
        int mode;
        while (parsed_bytes < BYTE_TARGET) begin
            if ($urandom_range(0, 19) == 0) begin
                sender_idles  = ($urandom_range(0, 2) != 0);
                reader_stalls = ($urandom_range(0, 2) != 0);
            end
            pick = $urandom_range(0, 39);
            if (pick < 30) begin
                mode = $urandom_range(0, 9);
                build_sentence($urandom_range(0, KIND_SHORT), 1'b1);
                add_checksum(mode == 6 ? SUM_WRONG : mode == 7 ? SUM_LOWER :
                             mode == 8 ? SUM_JUNK : SUM_GOOD);
                send_line();
            end else if (pick < 34) begin
                repeat ($urandom_range(1, 6)) line_buf.push_back(8'($urandom_range(0, 255)));
                send_line();
            end else if (pick < 39) begin
                build_sentence($urandom_range(0, KIND_SHORT), 1'b1);
                add_checksum(SUM_GOOD);
                line_buf = line_buf[0:$urandom_range(1, line_buf.size() - 1) - 1];
                send_line();
            end else begin
                pause_until_drained();
            end
        end
    endtask

    initial begin
        int code_count;
        i_rst_n      <= 1'b0;
        push         <= 1'b0;
        i_byte_in    <= 8'd0;
        fail_count    = 0;
        parsed_bytes  = 0;
        results_checked = 0;
        quiet_cycles  = 0;
        sender_idles  = 1'b1;
        reader_stalls = 1'b1;
        foreach (codes_seen[i]) codes_seen[i] = 1'b0;
        clear_parser();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_commands();
        test_checksum_faults();
        test_restart_and_noise();
        test_backpressure();
        test_random_traffic();

        // Drain, then let a stray late result show up if there is one.
        push <= 1'b0;
        do @(posedge i_clk); while (sentence_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        code_count = 0;
        foreach (codes_seen[i]) code_count += codes_seen[i];
        $display("Checked %0d sentence results over %0d parsed bytes; %0d of 10 command codes seen.",
                 results_checked, parsed_bytes, code_count);
        $display("Included restarts, bad and lowercase digits, stray bytes and a stalled reader.");
        if (fail_count == 0) begin
            $display("command_sentence_checker_tb passed");
        end else begin
            $display("command_sentence_checker_tb failed");
        end
        $finish;
    end

endmodule
